>>> hw/rtl/bqd_pkg.sv
// Shared constants, register indexes and types of the biquad filter.
`default_nettype none

package bqd_pkg;

  // default widths of the top level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 20;
  localparam int STATE_WIDTH_DEF  = 32;

  // fixed fraction bits of coefficients, delay state and the accumulator
  localparam int COEF_FRAC  = 16;
  localparam int STATE_FRAC = 16;
  localparam int ACC_FRAC   = COEF_FRAC + STATE_FRAC;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_ONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_TWO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_TWO  = 3'd4;

  // request kinds carried in in_tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_PRESET = 1'b1;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } bqd_div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bqd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bqd_div
  import bqd_pkg::*;
#(
  parameter int NUM_W = 34,
  parameter int DEN_W = 19
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output bqd_div_stat_t         stat,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, quot_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quot_r <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quot_r <= {quot_r[NUM_W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

`default_nettype wire

>>> hw/rtl/biquad_df2_filter.sv
// Direct form II biquad section on one shared multiply-accumulate unit.
//
//  channel | direction | beat content
//  --------+-----------+--------------------------------------------------
//  cfg_    | in        | cfg_index register index, cfg_data coefficient
//  in_     | in        | tdata sample_in, tuser req_type (0 sample, 1 preset)
//  out_    | out       | tdata sample_out, tuser saturated
//
// A sample beat runs through these steps from acceptance until the block is
// ready again: take the beat, the five products through the single
// multiplier, one more step per product chain for the registered product to
// reach the accumulator, round the state and round the output.
// A preset beat passes ST_PRE and waits in ST_DIV for the one-bit-per-cycle
// divider, or returns to idle from ST_PRE when 1 + a1 + a2 is zero.
// Reset (rst_n low, synchronous) clears the coefficients and both delay
// registers. The result sits in an output register; a new beat is taken while
// it waits, and only the final output step stalls when the previous result has
// not been taken.
`default_nettype none

module biquad_df2_filter
  import bqd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF,
  localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_WIDTH-1:0] cfg_data,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [DATA_W-1:0]     in_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  input  wire logic [0:0]            in_tuser,   // [0] req_type

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [DATA_W-1:0]     out_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
  output logic      [0:0]            out_tuser   // [0] saturated
);

  // input sample aligned to the accumulator's fraction point
  localparam int XA_SHIFT = ACC_FRAC - (SAMPLE_WIDTH - 1);
  localparam int XA_W     = SAMPLE_WIDTH + XA_SHIFT;
  localparam int CMAX     = (COEF_WIDTH > COEF_FRAC) ? COEF_WIDTH : COEF_FRAC;
  localparam int ACC_W    = STATE_WIDTH + CMAX + 2;
  localparam int SUM_W    = ACC_W + 1;
  localparam int PROD_W   = COEF_WIDTH + STATE_WIDTH;
  localparam int W_SHIFT  = ACC_FRAC - STATE_FRAC;
  localparam int Y_SHIFT  = XA_SHIFT;
  localparam int RW_W     = SUM_W - W_SHIFT;
  localparam int RY_W     = SUM_W - Y_SHIFT;
  // preset divider widths
  localparam int DBASE    = (COEF_WIDTH > COEF_FRAC + 1) ? COEF_WIDTH : COEF_FRAC + 1;
  localparam int DEN_W    = DBASE + 2;
  localparam int NUM_W    = ((XA_W > DEN_W) ? XA_W : DEN_W) + 1;
  localparam int CMP_W    = ((NUM_W > STATE_WIDTH) ? NUM_W : STATE_WIDTH) + 1;

  localparam logic [SUM_W-1:0] W_HALF = SUM_W'(1) << (W_SHIFT - 1);
  localparam logic [SUM_W-1:0] Y_HALF = SUM_W'(1) << (Y_SHIFT - 1);
  localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << COEF_FRAC;
  localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(1) << (STATE_WIDTH - 1);
  localparam logic [CMP_W-1:0] LIM_POS = LIM_NEG - CMP_W'(1);
  localparam logic [STATE_WIDTH-1:0]  ST_MAX = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
  localparam logic [STATE_WIDTH-1:0]  ST_MIN = {1'b1, {(STATE_WIDTH - 1){1'b0}}};
  localparam logic [SAMPLE_WIDTH-1:0] SM_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SM_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_DIV,
    ST_FB0, ST_FB1, ST_FB2, ST_WR,
    ST_FF0, ST_FF1, ST_FF2, ST_FF3, ST_OUT
  } state_t;

  state_t state_r;

  // coefficient registers, Q4.16
  logic signed [COEF_WIDTH-1:0] a1_r, a2_r, b0_r, b1_r, b2_r;

  // delay line and working registers
  logic signed [STATE_WIDTH-1:0] d1_r, d2_r, w_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [DEN_W-1:0]       den_r;
  logic                          neg_r;
  logic                          clip_r;

  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;
  logic                    out_sat_r;

  logic in_beat;
  logic out_free;

  logic signed [SAMPLE_WIDTH-1:0] x_in;
  logic signed [ACC_W-1:0]        xa_ext;
  logic signed [DEN_W-1:0]        den_c;

  logic signed [COEF_WIDTH-1:0]  mul_c;
  logic signed [STATE_WIDTH-1:0] mul_s;
  logic signed [PROD_W-1:0]      mul_p;

  logic [SUM_W-1:0]        rw_sum, ry_sum;
  logic [RW_W-1:0]         rw;
  logic [RY_W-1:0]         ry;
  logic                    w_fits, y_fits;
  logic [STATE_WIDTH-1:0]  w_sat;
  logic [SAMPLE_WIDTH-1:0] y_sat;

  logic [ACC_W-1:0] acc_neg;
  logic [XA_W-1:0]  n_mag;
  logic [DEN_W-1:0] d_mag;
  logic [NUM_W-1:0] div_num;
  logic             div_start;
  bqd_div_stat_t    div_stat;
  logic [NUM_W-1:0] div_quot;
  logic [CMP_W-1:0] q_ext, q_neg;
  logic [STATE_WIDTH-1:0] pre_w;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);
  assign out_tuser  = out_sat_r;

  assign x_in   = in_tdata[SAMPLE_WIDTH-1:0];
  assign xa_ext = ACC_W'(x_in) <<< XA_SHIFT;
  // 1 + a1 + a2 in Q.16
  assign den_c  = DEN_W'(a1_r) + DEN_W'(a2_r) + DEN_ONE;

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_FB0:  begin mul_c = a1_r; mul_s = d1_r; end
      ST_FB1:  begin mul_c = a2_r; mul_s = d2_r; end
      ST_FF0:  begin mul_c = b0_r; mul_s = w_r;  end
      ST_FF1:  begin mul_c = b1_r; mul_s = d1_r; end
      ST_FF2:  begin mul_c = b2_r; mul_s = d2_r; end
      default: begin mul_c = a1_r; mul_s = d1_r; end
    endcase
  end

  assign mul_p = mul_c * mul_s;

  // round half up, then clip to the state width
  assign rw_sum = SUM_W'(acc_r) + W_HALF;
  assign rw     = rw_sum[SUM_W-1:W_SHIFT];
  assign w_fits = (&rw[RW_W-1:STATE_WIDTH-1]) || !(|rw[RW_W-1:STATE_WIDTH-1]);
  assign w_sat  = w_fits ? rw[STATE_WIDTH-1:0] : (rw[RW_W-1] ? ST_MIN : ST_MAX);

  // round half up, then clip to the sample width
  assign ry_sum = SUM_W'(acc_r) + Y_HALF;
  assign ry     = ry_sum[SUM_W-1:Y_SHIFT];
  assign y_fits = (&ry[RY_W-1:SAMPLE_WIDTH-1]) || !(|ry[RY_W-1:SAMPLE_WIDTH-1]);
  assign y_sat  = y_fits ? ry[SAMPLE_WIDTH-1:0] : (ry[RY_W-1] ? SM_MIN : SM_MAX);

  // preset: magnitudes and rounding offset for round-to-nearest division
  assign acc_neg   = -acc_r;
  assign n_mag     = acc_r[ACC_W-1] ? acc_neg[XA_W-1:0] : acc_r[XA_W-1:0];
  assign d_mag     = den_r[DEN_W-1] ? -den_r : den_r;
  assign div_num   = NUM_W'(n_mag) + NUM_W'(d_mag >> 1);
  assign div_start = (state_r == ST_PRE) && (den_r != '0);

  // apply the sign to the quotient and clip to the state width
  assign q_ext = CMP_W'(div_quot);
  assign q_neg = -q_ext;
  always_comb begin
    if (neg_r) begin
      pre_w = (q_ext > LIM_NEG) ? ST_MIN : q_neg[STATE_WIDTH-1:0];
    end else begin
      pre_w = (q_ext > LIM_POS) ? ST_MAX : q_ext[STATE_WIDTH-1:0];
    end
  end

  bqd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_mag),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // coefficient writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r <= '0;
      a2_r <= '0;
      b0_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FB_COEF_ONE:  a1_r <= cfg_data;
        REG_FB_COEF_TWO:  a2_r <= cfg_data;
        REG_FF_COEF_ZERO: b0_r <= cfg_data;
        REG_FF_COEF_ONE:  b1_r <= cfg_data;
        REG_FF_COEF_TWO:  b2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: state, delay line, accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken beat; in ST_OUT the next result takes its place instead
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= mul_p;
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            acc_r <= xa_ext;
            den_r <= den_c;
            state_r <= (in_tuser[0] == REQ_PRESET) ? ST_PRE : ST_FB0;
          end
        end
        ST_PRE: begin
          neg_r <= acc_r[ACC_W-1] ^ den_r[DEN_W-1];
          if (den_r == '0) begin
            // no steady state exists: clear the delay line
            d1_r    <= '0;
            d2_r    <= '0;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            d1_r    <= pre_w;
            d2_r    <= pre_w;
            state_r <= ST_IDLE;
          end
        end
        ST_FB0: state_r <= ST_FB1;
        ST_FB1: begin
          acc_r   <= acc_r - ACC_W'(prod_r);
          state_r <= ST_FB2;
        end
        ST_FB2: begin
          acc_r   <= acc_r - ACC_W'(prod_r);
          state_r <= ST_WR;
        end
        ST_WR: begin
          w_r     <= w_sat;
          clip_r  <= !w_fits;
          acc_r   <= '0;
          state_r <= ST_FF0;
        end
        ST_FF0: state_r <= ST_FF1;
        ST_FF1: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          state_r <= ST_FF2;
        end
        ST_FF2: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          state_r <= ST_FF3;
        end
        ST_FF3: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the previous result has left the output register
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= y_sat;
            out_sat_r   <= clip_r || !y_fits;
            d2_r        <= d1_r;
            d1_r        <= w_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the preset wait");

  // a finished sample always shows up on the output at the next edge
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && out_free |=> out_tvalid)
    else $error("finished sample did not reach the output register");

  // the delay line holds while products are being accumulated
  a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && (state_r != ST_PRE) && (state_r != ST_DIV) &&
    (state_r != ST_OUT) |=> $stable(d1_r) && $stable(d2_r))
    else $error("delay line changed in the middle of a sample");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench of the direct form II biquad section.
module tb
  import bqd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = SAMPLE_WIDTH_DEF;
  localparam int COEF_W      = COEF_WIDTH_DEF;
  localparam int STATE_W     = STATE_WIDTH_DEF;
  localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
  localparam int SAMPLE_FRAC = SAMPLE_W - 1;
  localparam int NUM_COEF    = 5;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  // a preset can still be in its division after the drain; leave margin before a write
  localparam int SETTLE_CYCLES = 48;
  // cycles without any accepted beat before the run is declared hung
  localparam int STALL_LIMIT = 4000;

  localparam int SEGMENTS_PER_PHASE = 4;
  localparam int BEATS_PER_SEGMENT  = 84;
  localparam int PRESET_PCT         = 12;

  localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
  localparam int COEF_MAX   = 2 ** (COEF_W - 1) - 1;
  localparam int COEF_MIN   = -(2 ** (COEF_W - 1));
  localparam int COEF_UNITY = 2 ** COEF_FRAC;

  // spans of the moderate coefficient draws, Q4.16
  localparam int FB_ONE_SPAN = 2 * COEF_UNITY;
  localparam int FB_TWO_SPAN = COEF_UNITY;
  localparam int FF_SPAN     = COEF_UNITY;

  // indexes past the last coefficient: writes there must leave everything alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_FF_COEF_TWO + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  typedef enum logic [1:0] {
    PACE_SLOW_SINK,    // sender gaps rare, receiver stalls often
    PACE_SLOW_SOURCE,  // sender gaps often, receiver stalls rare
    PACE_FULL          // no gaps, no stalls
  } pace_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_BEAT
  } row_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic                       sat;
  } filt_out_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [COEF_W-1:0]     val;
    logic                  req;
    logic [SAMPLE_W-1:0]   x;
    bit                    typed;
    filt_out_t             known;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;
  logic [0:0]           out_tuser;

  // predictor copy of the coefficient registers and the delay line
  longint signed coef_q [NUM_COEF];
  longint signed w_one;
  longint signed w_two;

  filt_out_t   pending_filtered[$];
  dir_row_t    dir_rows[$];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;
  int          fail_count = 0;

  biquad_df2_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [SAMPLE_W-1:0] sample_in
    .in_tuser   (in_tuser),   // [0] req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [SAMPLE_W-1:0] sample_out
    .out_tuser  (out_tuser)   // [0] saturated
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the section
  // ---------------------------------------------------------------------------

  // add one half, then floor: round half up
  function automatic longint signed round_half_up(longint signed v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // clamp to a signed width; flag any clipping
  function automatic longint signed clip_width(longint signed v, int w, inout bit hit);
    longint signed hi;
    longint signed lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Advance the predicted section by one request. A sample runs the
  // recursion and yields one output; a preset loads the steady state
  // x / (1 + a1 + a2), rounded to nearest with ties away from zero.
  function automatic void run_section(input logic req, input logic signed [SAMPLE_W-1:0] x,
                                      output bit has_out, output filt_out_t res);
    longint signed xa;
    longint signed acc;
    longint signed w;
    longint signed yacc;
    longint signed y;
    longint signed den;
    longint signed num;
    longint signed den_mag;
    longint signed quo;
    bit            hit;
    hit     = 1'b0;
    has_out = 1'b0;
    res     = '0;
    xa = x;
    xa = xa <<< (ACC_FRAC - SAMPLE_FRAC);
    if (req == REQ_PRESET) begin
      den = (64'sd1 <<< COEF_FRAC) + coef_q[REG_FB_COEF_ONE] + coef_q[REG_FB_COEF_TWO];
      if (den == 0) begin
        // no steady state exists: clear the delay line
        w_one = 0;
        w_two = 0;
      end else begin
        num     = (xa < 0) ? -xa : xa;
        den_mag = (den < 0) ? -den : den;
        quo     = (num + den_mag / 2) / den_mag;
        if ((xa < 0) != (den < 0)) quo = -quo;
        w_one = clip_width(quo, STATE_W, hit);
        w_two = w_one;
      end
    end else begin
      acc  = xa - coef_q[REG_FB_COEF_ONE] * w_one - coef_q[REG_FB_COEF_TWO] * w_two;
      w    = clip_width(round_half_up(acc, ACC_FRAC - STATE_FRAC), STATE_W, hit);
      yacc = coef_q[REG_FF_COEF_ZERO] * w + coef_q[REG_FF_COEF_ONE] * w_one
           + coef_q[REG_FF_COEF_TWO] * w_two;
      y    = clip_width(round_half_up(yacc, ACC_FRAC - SAMPLE_FRAC), SAMPLE_W, hit);
      w_two   = w_one;
      w_one   = w;
      res.y   = y[SAMPLE_W-1:0];
      res.sat = hit;
      has_out = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every one starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  function automatic void apply_pace(pace_t p);
    case (p)
      PACE_SLOW_SINK: begin
        send_gap_pct   = 12;
        recv_stall_pct = 86;
      end
      PACE_SLOW_SOURCE: begin
        send_gap_pct   = 86;
        recv_stall_pct = 12;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, int value);
    dir_row_t r;
    r       = '{kind: ROW_WRITE, default: '0};
    r.idx   = idx;
    r.val   = COEF_W'(value);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_beat(logic req, int x);
    dir_row_t r;
    r      = '{kind: ROW_BEAT, default: '0};
    r.req  = req;
    r.x    = SAMPLE_W'(x);
    dir_rows.push_back(r);
  endfunction

  // beat whose result is obvious by inspection: type it in
  function automatic void add_known(logic req, int x, int y, logic sat);
    dir_row_t r;
    r           = '{kind: ROW_BEAT, default: '0};
    r.req       = req;
    r.x         = SAMPLE_W'(x);
    r.typed     = 1'b1;
    r.known.y   = SAMPLE_W'(y);
    r.known.sat = sat;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(int unsigned span);
    case ($urandom_range(9))
      0:       return COEF_W'(COEF_MAX);
      1:       return COEF_W'(COEF_MIN);
      2:       return '0;
      3:       return COEF_W'($urandom());
      default: return COEF_W'($urandom_range(2 * span) - span);
    endcase
  endfunction

  // Write one register. Leave cfg_valid high so that writes go back to back;
  // the caller drops it once the batch is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_FF_COEF_TWO) coef_q[idx] = longint'($signed(val));
    @(negedge clk);
  endtask

  // Offer one beat after a random gap. Leave in_tvalid high on return so a
  // following beat never sees a drop and a raise in the same step.
  task automatic send_beat(logic req, logic [SAMPLE_W-1:0] x, bit typed, filt_out_t known);
    bit        has_out;
    filt_out_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= DATA_W'(x);
    do @(posedge clk); while (!in_tready);
    run_section(req, x, has_out, res);
    if (has_out) pending_filtered.push_back(typed ? known : res);
    @(negedge clk);
  endtask

  // Drop the input, drain every pending output, then let a preset finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_filtered.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_beat();
    logic                req;
    logic [SAMPLE_W-1:0] x;
    req = ($urandom_range(99) < PRESET_PCT) ? REQ_PRESET : REQ_SAMPLE;
    case ($urandom_range(7))
      0:       x = SAMPLE_W'(SAMPLE_MAX);
      1:       x = SAMPLE_W'(SAMPLE_MIN);
      2, 3:    x = SAMPLE_W'($urandom_range(4095) - 2048);
      default: x = SAMPLE_W'($urandom());
    endcase
    send_beat(req, x, 1'b0, '0);
  endtask

  // One pacing phase: several coefficient sets, each followed by a burst of
  // random beats. Feedback spans are kept mostly near the stable region so
  // that long runs stay out of saturation as well as in it.
  task automatic random_phase(pace_t p);
    apply_pace(p);
    for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
      settle();
      write_reg(REG_FB_COEF_ONE, pick_coef(FB_ONE_SPAN));
      write_reg(REG_FB_COEF_TWO, pick_coef(FB_TWO_SPAN));
      write_reg(REG_FF_COEF_ZERO, pick_coef(FF_SPAN));
      write_reg(REG_FF_COEF_ONE, pick_coef(FF_SPAN));
      write_reg(REG_FF_COEF_TWO, pick_coef(FF_SPAN));
      if ($urandom_range(2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  COEF_W'($urandom()));
      cfg_valid <= 1'b0;
      repeat (BEATS_PER_SEGMENT) random_beat();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random, sample at the rising edge, check each beat
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_filtered.size() == 0) begin
        $error("unexpected output beat: sample_out %0d saturated %0d",
               $signed(out_tdata[SAMPLE_W-1:0]), out_tuser[0]);
        fail_count++;
      end else begin
        want = pending_filtered.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.y) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 want.y, $signed(out_tdata[SAMPLE_W-1:0]));
          fail_count++;
        end
        if (out_tuser[0] !== want.sat) begin
          $error("saturated mismatch: expected %0d, actual %0d", want.sat, out_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_SAMPLE;
    for (int i = 0; i < NUM_COEF; i++) coef_q[i] = 0;
    w_one = 0;
    w_two = 0;
    apply_pace(PACE_SLOW_SINK);

    // Directed table. With both feedback taps and the late feedforward taps
    // at zero, y is just b0 * 2x rescaled, so those rows are typed in.
    // All coefficients are zero out of reset: output is zero.
    add_known(REQ_SAMPLE, SAMPLE_MAX, 0, 1'b0);
    add_known(REQ_SAMPLE, SAMPLE_MIN, 0, 1'b0);
    // b0 = 1.0 passes the input straight through
    add_write(REG_FF_COEF_ZERO, COEF_UNITY);
    add_known(REQ_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    add_known(REQ_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    add_known(REQ_SAMPLE, 1, 1, 1'b0);
    add_known(REQ_SAMPLE, 0, 0, 1'b0);
    // largest gain clips full-scale input to the same rail
    add_write(REG_FF_COEF_ZERO, COEF_MAX);
    add_known(REQ_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    add_known(REQ_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    // most negative gain clips to the opposite rail
    add_write(REG_FF_COEF_ZERO, COEF_MIN);
    add_known(REQ_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    add_known(REQ_SAMPLE, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    // 1 + a1 + a2 == 0: a preset clears the delay line, so the next output is zero
    add_write(REG_FB_COEF_ONE, -COEF_UNITY);
    add_write(REG_FF_COEF_ZERO, 0);
    add_write(REG_FF_COEF_ONE, COEF_UNITY);
    add_beat(REQ_PRESET, 12345);
    add_known(REQ_SAMPLE, 0, 0, 1'b0);
    add_beat(REQ_SAMPLE, 1000);
    // denominator of one LSB: the preset quotient saturates the state
    add_write(REG_FB_COEF_ONE, 1 - COEF_UNITY);
    add_beat(REQ_PRESET, SAMPLE_MAX);
    add_beat(REQ_SAMPLE, 0);
    // every coefficient at an extreme
    add_write(REG_FB_COEF_ONE, COEF_MAX);
    add_write(REG_FB_COEF_TWO, COEF_MAX);
    add_write(REG_FF_COEF_ZERO, COEF_MAX);
    add_write(REG_FF_COEF_ONE, COEF_MIN);
    add_write(REG_FF_COEF_TWO, COEF_MIN);
    add_beat(REQ_PRESET, SAMPLE_MIN);
    add_beat(REQ_SAMPLE, SAMPLE_MIN);
    add_beat(REQ_SAMPLE, SAMPLE_MAX);
    // negative denominator flips the sign of the preset quotient
    add_write(REG_FB_COEF_ONE, COEF_MIN);
    add_write(REG_FB_COEF_TWO, COEF_MIN);
    add_beat(REQ_PRESET, SAMPLE_MAX);
    add_beat(REQ_SAMPLE, 12345);
    add_beat(REQ_SAMPLE, -1);
    // writes past the last register change nothing
    add_write(REG_SPARE_FIRST, COEF_MAX);
    add_write(REG_SPARE_LAST, COEF_MIN);
    add_beat(REQ_SAMPLE, 777);
    // a plain low-pass section settling from a preset
    add_write(REG_FB_COEF_ONE, -100000);
    add_write(REG_FB_COEF_TWO, 40000);
    add_write(REG_FF_COEF_ZERO, 5000);
    add_write(REG_FF_COEF_ONE, 10000);
    add_write(REG_FF_COEF_TWO, 5000);
    add_beat(REQ_PRESET, 16384);
    add_beat(REQ_SAMPLE, 16384);
    add_beat(REQ_SAMPLE, 16384);

    // hold reset, release it at a falling edge
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the table. Drain before a write that follows a beat, and drop
    // cfg_valid before the first beat after a batch of writes.
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (i > 0 && dir_rows[i-1].kind == ROW_BEAT) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_beat(dir_rows[i].req, dir_rows[i].x, dir_rows[i].typed, dir_rows[i].known);
      end
    end

    random_phase(PACE_SLOW_SINK);
    random_phase(PACE_SLOW_SOURCE);
    random_phase(PACE_FULL);

    settle();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
